// ----- sv/q24f_pkg.sv -----
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU package
// Shared word types, command and status codes, and pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package q24f_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 32;
    localparam int NUM_W         = DATA_W + FRACTION_BITS;
    localparam int DIV_STEPS     = 2;
    localparam int DIV_STAGES    = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_NUM_W     = DIV_STAGES * DIV_STEPS;
    localparam int REM_W         = DATA_W + 1;
    localparam int MUL_LAT       = 3;
    localparam int DIV_LAT       = DIV_STAGES + 3;

    localparam logic [DATA_W-1:0] RAW_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RAW_MIN = 32'h8000_0000;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_SUB      = 4'd1;
    localparam logic [3:0] CMD_MUL      = 4'd2;
    localparam logic [3:0] CMD_DIV      = 4'd3;
    localparam logic [3:0] CMD_GT       = 4'd4;
    localparam logic [3:0] CMD_LT       = 4'd5;
    localparam logic [3:0] CMD_GE       = 4'd6;
    localparam logic [3:0] CMD_LE       = 4'd7;
    localparam logic [3:0] CMD_EQ       = 4'd8;
    localparam logic [3:0] CMD_NE       = 4'd9;
    localparam logic [3:0] CMD_MIN      = 4'd10;
    localparam logic [3:0] CMD_MAX      = 4'd11;
    localparam logic [3:0] CMD_INC      = 4'd12;
    localparam logic [3:0] CMD_DEC      = 4'd13;
    localparam logic [3:0] CMD_TO_INT   = 4'd14;
    localparam logic [3:0] CMD_FROM_INT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]               command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } q24f_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic [1:0]               status;
    } q24f_out_t;

endpackage

`default_nettype wire

// ----- sv/q24f_mul.sv -----
// ----------------------------------------------------------------------------
// Q24.8 multiplier
// Three-stage signed multiply with round half away from zero and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module q24f_mul
    import q24f_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [DATA_W-1:0] operand_a,
    input  wire logic signed [DATA_W-1:0] operand_b,
    output q24f_out_t                     product
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       neg_reg;
    logic [2*DATA_W-1:0]        rnd_reg;
    logic [2*DATA_W-1:0]        mag_next;
    logic [2*DATA_W-1:0]        rnd_next;
    q24f_out_t                  res_reg;
    q24f_out_t                  res_next;
    logic                       hi_w;

    always_comb
    begin
        mag_next = prod_reg[2*DATA_W-1] ? ((2*DATA_W)'(0) - prod_reg) : prod_reg;
        rnd_next = (mag_next + ((2*DATA_W)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    end

    always_comb
    begin
        hi_w = |rnd_reg[2*DATA_W-1:DATA_W];
        res_next.compare_true = 1'b0;
        res_next.status       = ST_OK;
        if (neg_reg)
        begin
            if (hi_w || (rnd_reg[DATA_W-1] && (|rnd_reg[DATA_W-2:0])))
            begin
                res_next.result_value = RAW_MIN;
                res_next.status       = ST_OVF;
            end
            else
            begin
                res_next.result_value = DATA_W'(DATA_W'(0) - rnd_reg[DATA_W-1:0]);
            end
        end
        else
        begin
            if (hi_w || rnd_reg[DATA_W-1])
            begin
                res_next.result_value = RAW_MAX;
                res_next.status       = ST_OVF;
            end
            else
            begin
                res_next.result_value = rnd_reg[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= operand_a * operand_b;
        neg_reg  <= prod_reg[2*DATA_W-1];
        rnd_reg  <= rnd_next;
        res_reg  <= res_next;
    end

    assign product = res_reg;

endmodule

`default_nettype wire

// ----- sv/q24f_div.sv -----
// ----------------------------------------------------------------------------
// Q24.8 divider
// Pipelined restoring division, two quotient bits per stage, then round
// half away from zero, saturation and divide-by-zero handling.
// ----------------------------------------------------------------------------
`default_nettype none

module q24f_div
    import q24f_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [DATA_W-1:0] operand_a,
    input  wire logic signed [DATA_W-1:0] operand_b,
    output q24f_out_t                     quotient
);

    typedef struct packed {
        logic neg;
        logic a_neg;
        logic a_zero;
        logic b_zero;
    } q24f_dflag_t;

    logic [REM_W-1:0]     rem_reg  [DIV_STAGES+1];
    logic [DIV_NUM_W-1:0] nq_reg   [DIV_STAGES+1];
    logic [DATA_W-1:0]    den_reg  [DIV_STAGES+1];
    q24f_dflag_t          flg_reg  [DIV_STAGES+1];

    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;

    logic [DIV_NUM_W:0]   q_reg;
    q24f_dflag_t          qflg_reg;
    q24f_out_t            res_reg;
    q24f_out_t            res_next;
    logic                 up_w;
    logic                 hi_w;

    always_comb
    begin
        mag_a = operand_a[DATA_W-1] ? (DATA_W'(0) - operand_a) : operand_a;
        mag_b = operand_b[DATA_W-1] ? (DATA_W'(0) - operand_b) : operand_b;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]        <= '0;
        nq_reg[0]         <= DIV_NUM_W'({mag_a, FRACTION_BITS'(0)});
        den_reg[0]        <= mag_b;
        flg_reg[0].neg    <= operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        flg_reg[0].a_neg  <= operand_a[DATA_W-1];
        flg_reg[0].a_zero <= (operand_a == '0);
        flg_reg[0].b_zero <= (operand_b == '0);
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0]     rem_next;
        logic [DIV_NUM_W-1:0] nq_next;

        always_comb
        begin
            rem_next = rem_reg[s-1];
            nq_next  = nq_reg[s-1];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_next = {rem_next[REM_W-2:0], nq_next[DIV_NUM_W-1]};
                if (rem_next >= {1'b0, den_reg[s-1]})
                begin
                    rem_next = rem_next - {1'b0, den_reg[s-1]};
                    nq_next  = {nq_next[DIV_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    nq_next  = {nq_next[DIV_NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            nq_reg[s]  <= nq_next;
            den_reg[s] <= den_reg[s-1];
            flg_reg[s] <= flg_reg[s-1];
        end
    end

    assign up_w = ({rem_reg[DIV_STAGES], 1'b0} >= {2'b00, den_reg[DIV_STAGES]});

    always_comb
    begin
        hi_w = |q_reg[DIV_NUM_W:DATA_W];
        res_next.compare_true = 1'b0;
        res_next.status       = ST_OK;
        res_next.result_value = q_reg[DATA_W-1:0];
        if (qflg_reg.b_zero)
        begin
            res_next.status = ST_DIV0;
            if (qflg_reg.a_neg)
            begin
                res_next.result_value = RAW_MIN;
            end
            else if (qflg_reg.a_zero)
            begin
                res_next.result_value = '0;
            end
            else
            begin
                res_next.result_value = RAW_MAX;
            end
        end
        else if (qflg_reg.neg)
        begin
            if (hi_w || (q_reg[DATA_W-1] && (|q_reg[DATA_W-2:0])))
            begin
                res_next.result_value = RAW_MIN;
                res_next.status       = ST_OVF;
            end
            else
            begin
                res_next.result_value = DATA_W'(DATA_W'(0) - q_reg[DATA_W-1:0]);
            end
        end
        else if (hi_w || q_reg[DATA_W-1])
        begin
            res_next.result_value = RAW_MAX;
            res_next.status       = ST_OVF;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= {1'b0, nq_reg[DIV_STAGES]} + {DIV_NUM_W'(0), up_w};
        qflg_reg <= flg_reg[DIV_STAGES];
        res_reg  <= res_next;
    end

    assign quotient = res_reg;

endmodule

`default_nettype wire

// ----- sv/q24_8_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Stateless signed Q24.8 unit: add, sub, mul, div, compares, min, max,
// inc, dec and integer conversions, with saturation and status.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  input     request               accepted when start is high and busy is low
//  output    response              valid for one cycle while done is high
//
//  One word is accepted every cycle; busy is always low.
//  Every word passes through one pipeline whose depth is set by
//  the divider pipeline, which retires two quotient bits per stage.
//  All commands share that depth, so results leave in input order.
//  Reset clears only the valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module q24_8_fixed_point_alu_top
    import q24f_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  q24f_in_t       request,
    output logic           done,
    output q24f_out_t      response
);

    typedef struct packed {
        logic [3:0] command;
        q24f_out_t  res;
    } q24f_stage_t;

    logic        in_valid_reg;
    q24f_in_t    in_reg;

    q24f_stage_t smp_reg [DIV_LAT];
    logic        smp_vld_reg [DIV_LAT];
    q24f_out_t   mul_reg [DIV_LAT-MUL_LAT];
    q24f_out_t   smp_next;
    q24f_out_t   mul_out;
    q24f_out_t   div_out;
    q24f_out_t   res_next;
    q24f_out_t   res_reg;
    logic        done_reg;

    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W:0]   sum_w;
    logic signed [DATA_W:0]   diff_w;
    logic signed [DATA_W:0]   inc_w;
    logic signed [DATA_W:0]   dec_w;
    logic signed [DATA_W:0]   ti_w;
    logic signed [NUM_W-1:0]  fi_w;

    function automatic q24f_out_t sat33(input logic [DATA_W:0] v);
        q24f_out_t r;
        r.compare_true = 1'b0;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r.status       = ST_OVF;
            r.result_value = v[DATA_W] ? RAW_MIN : RAW_MAX;
        end
        else
        begin
            r.status       = ST_OK;
            r.result_value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    assign busy = 1'b0;
    assign a    = in_reg.operand_a;
    assign b    = in_reg.operand_b;

    always_comb
    begin
        sum_w  = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        diff_w = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        inc_w  = {a[DATA_W-1], a} + (DATA_W+1)'(1);
        dec_w  = {a[DATA_W-1], a} - (DATA_W+1)'(1);
        ti_w   = {a[DATA_W-1], a}
                 + (a[DATA_W-1] ? (DATA_W+1)'((1 << FRACTION_BITS) - 1) : (DATA_W+1)'(0));
        fi_w   = {{FRACTION_BITS{a[DATA_W-1]}}, a} <<< FRACTION_BITS;

        smp_next.result_value = '0;
        smp_next.compare_true = 1'b0;
        smp_next.status       = ST_OK;
        unique case (in_reg.command)
            CMD_ADD:  smp_next = sat33(sum_w);
            CMD_SUB:  smp_next = sat33(diff_w);
            CMD_INC:  smp_next = sat33(inc_w);
            CMD_DEC:  smp_next = sat33(dec_w);
            CMD_GT:   smp_next.compare_true = (a > b);
            CMD_LT:   smp_next.compare_true = (a < b);
            CMD_GE:   smp_next.compare_true = (a >= b);
            CMD_LE:   smp_next.compare_true = (a <= b);
            CMD_EQ:   smp_next.compare_true = (a == b);
            CMD_NE:   smp_next.compare_true = (a != b);
            CMD_MIN:  smp_next.result_value = (a > b) ? b : a;
            CMD_MAX:  smp_next.result_value = (a < b) ? b : a;
            CMD_TO_INT:
            begin
                smp_next.result_value = DATA_W'(ti_w >>> FRACTION_BITS);
            end
            CMD_FROM_INT:
            begin
                if (fi_w[NUM_W-1:DATA_W-1] != {(FRACTION_BITS+1){a[DATA_W-1]}})
                begin
                    smp_next.status       = ST_OVF;
                    smp_next.result_value = a[DATA_W-1] ? RAW_MIN : RAW_MAX;
                end
                else
                begin
                    smp_next.result_value = fi_w[DATA_W-1:0];
                end
            end
            default: smp_next.result_value = '0;
        endcase
    end

    q24f_mul u_mul (
        .clk       (clk),
        .operand_a (a),
        .operand_b (b),
        .product   (mul_out)
    );

    q24f_div u_div (
        .clk       (clk),
        .operand_a (a),
        .operand_b (b),
        .quotient  (div_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                smp_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            in_valid_reg   <= start && !busy;
            smp_vld_reg[0] <= in_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                smp_vld_reg[i] <= smp_vld_reg[i-1];
            end
            done_reg <= smp_vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg             <= request;
        smp_reg[0].command <= in_reg.command;
        smp_reg[0].res     <= smp_next;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            smp_reg[i].command <= smp_reg[i-1].command;
            smp_reg[i].res     <= smp_reg[i-1].res;
        end
        mul_reg[0] <= mul_out;
        for (int i = 1; i < DIV_LAT - MUL_LAT; i++)
        begin
            mul_reg[i] <= mul_reg[i-1];
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        unique case (smp_reg[DIV_LAT-1].command)
            CMD_MUL: res_next = mul_reg[DIV_LAT-MUL_LAT-1];
            CMD_DIV: res_next = div_out;
            default: res_next = smp_reg[DIV_LAT-1].res;
        endcase
    end

    assign done     = done_reg;
    assign response = res_reg;

endmodule

`default_nettype wire
